/* sv/tfsc_pkg.sv */
package tfsc_pkg;

  localparam int unsigned MV_W       = 12;
  localparam int unsigned OHM_W      = 16;
  localparam int unsigned DUTY_W     = 7;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned FLAG_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Shared restoring divider: the widest dividend is sample_mv * bias_ohms.
  localparam int unsigned NUM_W = MV_W + OHM_W;
  localparam int unsigned DEN_W = OHM_W;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam int unsigned MUL_W = 2 * OHM_W;

  localparam logic [OHM_W-1:0]   BIAS_RST     = 16'd10000;
  localparam logic [OHM_W-1:0]   ENABLE_RST   = 16'd5447;
  localparam logic [OHM_W-1:0]   OVERTEMP_RST = 16'd2985;
  localparam logic [MV_W-1:0]    MARGIN_RST   = 12'd50;
  localparam logic [MV_W-1:0]    POT_FULL_RST = 12'd1650;
  localparam logic [RATIO_W-1:0] RATIO_RST    = 16'd1;

  localparam logic [OHM_W-1:0]  RATIO_SCALE = 16'd1000;
  localparam logic [OHM_W-1:0]  PCT_SCALE   = 16'd100;
  localparam logic [DUTY_W-1:0] DUTY_FULL   = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_OFF    = 7'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRONT_MODE = 3'd0,
    REG_BIAS       = 3'd1,
    REG_ENABLE     = 3'd2,
    REG_OVERTEMP   = 3'd3,
    REG_MARGIN     = 3'd4,
    REG_POT_FULL   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_RES   = 2'd0,
    OP_RATIO = 2'd1,
    OP_DUTY  = 2'd2,
    OP_POT   = 2'd3
  } div_op_e;

  typedef struct packed {
    logic    load;
    logic    start;
    div_op_e op;
    logic    step;
    logic    finish;
    logic    res_ot;
    logic    mark_ot;
    logic    duty_zero;
    logic    front_duty;
    logic    write;
  } cmd_t;

  typedef struct packed {
    logic front;
    logic front_direct;
    logic near;
    logic div_last;
    logic op_res;
    logic res_le_ot;
    logic ref_zero;
    logic duty_zero;
    logic out_free;
  } status_t;

endpackage

/* sv/tfsc_ctrl.sv */
module tfsc_ctrl import tfsc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PLAN  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_FIN   = 6'b001000,
    ST_CLASS = 6'b010000,
    ST_WRITE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.op = OP_RES;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PLAN;
        end
      end
      ST_PLAN: begin
        if (status_i.front) begin
          if (status_i.front_direct) begin
            cmd_o.front_duty = 1'b1;
            state_d          = ST_WRITE;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.op    = OP_POT;
            state_d     = ST_DIV;
          end
        end else if (status_i.near) begin
          // Reading too close to the reference: treat as overtemp resistance.
          cmd_o.res_ot = 1'b1;
          state_d      = ST_CLASS;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_RES;
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = status_i.op_res ? ST_CLASS : ST_WRITE;
      end
      ST_CLASS: begin
        if (status_i.res_le_ot) begin
          cmd_o.mark_ot = 1'b1;
          if (status_i.ref_zero) begin
            state_d = ST_WRITE;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.op    = OP_RATIO;
            state_d     = ST_DIV;
          end
        end else if (status_i.duty_zero) begin
          cmd_o.duty_zero = 1'b1;
          state_d         = ST_WRITE;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_DUTY;
          state_d     = ST_DIV;
        end
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/tfsc_dpath.sv */
module tfsc_dpath import tfsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [MV_W-1:0]       ref_mv_i,
  input  logic [MV_W-1:0]       sample_mv_i,
  input  logic                  channel_i,
  input  logic                  period_end_i,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [DUTY_W-1:0]     duty_percent_o,
  output logic                  fan_channel_o,
  output logic                  over_temp_o,
  output logic                  fault_send_o,
  output logic [FLAG_W-1:0]     fault_flags_o,
  output logic [RATIO_W-1:0]    enclosure_ratio_o,
  output logic [RATIO_W-1:0]    dcdc_ratio_o
);

  // Configuration registers.
  logic             front_q;
  logic [OHM_W-1:0] bias_q, enable_q, ot_ohm_q;
  logic [MV_W-1:0]  margin_q, pot_q;

  // Captured item and working registers.
  logic [MV_W-1:0]    ref_q, smp_q;
  logic               ch_q, pend_q;
  logic [NUM_W-1:0]   res_q, num_q;
  logic [DEN_W-1:0]   rem_q, den_q;
  logic [CNT_W-1:0]   cnt_q;
  div_op_e            op_q;
  logic [DUTY_W-1:0]  duty_q;
  logic [RATIO_W-1:0] ratio_q;
  logic               ot_flag_q, upd_q;

  // Period state and output register.
  logic [FLAG_W-1:0]  flags_q;
  logic [RATIO_W-1:0] encl_q, dcdc_q;
  logic               out_valid_q;

  logic [MV_W:0]      diff;
  logic [MV_W:0]      pot_lim;
  logic [DUTY_W-1:0]  front_duty_val;
  logic [OHM_W-1:0]   mul_a, mul_b;
  logic [MUL_W-1:0]   prod;
  logic [DEN_W-1:0]   den_sel;
  logic [DEN_W:0]     shifted, trial;
  logic               ge;
  logic [FLAG_W-1:0]  flags_new, ch_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q  <= 1'b0;
      bias_q   <= BIAS_RST;
      enable_q <= ENABLE_RST;
      ot_ohm_q <= OVERTEMP_RST;
      margin_q <= MARGIN_RST;
      pot_q    <= POT_FULL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRONT_MODE: front_q  <= cfg_data_i[0];
        REG_BIAS:       bias_q   <= cfg_data_i;
        REG_ENABLE:     enable_q <= cfg_data_i;
        REG_OVERTEMP:   ot_ohm_q <= cfg_data_i;
        REG_MARGIN:     margin_q <= cfg_data_i[MV_W-1:0];
        REG_POT_FULL:   pot_q    <= cfg_data_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  assign diff    = {1'b0, ref_q} - {1'b0, smp_q};
  assign pot_lim = {1'b0, pot_q} + {1'b0, margin_q};

  always_comb begin
    if (ref_q == '0) begin
      front_duty_val = DUTY_FULL;
    end else if (smp_q == '0 || {1'b0, smp_q} > pot_lim) begin
      front_duty_val = DUTY_OFF;
    end else begin
      front_duty_val = DUTY_FULL;
    end
  end

  // One multiplier forms the dividend for whichever quotient is started.
  always_comb begin
    case (cmd_i.op)
      OP_RES: begin
        mul_a   = OHM_W'(smp_q);
        mul_b   = bias_q;
        den_sel = DEN_W'(diff[MV_W-1:0]);
      end
      OP_RATIO: begin
        mul_a   = OHM_W'(smp_q);
        mul_b   = RATIO_SCALE;
        den_sel = DEN_W'(ref_q);
      end
      OP_DUTY: begin
        mul_a   = enable_q - res_q[OHM_W-1:0];
        mul_b   = PCT_SCALE;
        den_sel = enable_q - ot_ohm_q;
      end
      OP_POT: begin
        mul_a   = OHM_W'(smp_q);
        mul_b   = PCT_SCALE;
        den_sel = DEN_W'(pot_q);
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        den_sel = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  assign shifted = {rem_q, num_q[NUM_W-1]};
  assign ge      = (shifted >= {1'b0, den_q});
  assign trial   = shifted - {1'b0, den_q};

  assign ch_bit    = ch_q ? FLAG_W'(2) : FLAG_W'(1);
  assign flags_new = flags_q | (ot_flag_q ? ch_bit : '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ref_q     <= ref_mv_i;
      smp_q     <= sample_mv_i;
      ch_q      <= channel_i;
      pend_q    <= period_end_i;
      ot_flag_q <= 1'b0;
      upd_q     <= 1'b0;
    end
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      num_q <= prod[NUM_W-1:0];
      den_q <= den_sel;
      rem_q <= '0;
      cnt_q <= CNT_W'(NUM_W - 1);
    end
    if (cmd_i.step) begin
      rem_q <= ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      num_q <= {num_q[NUM_W-2:0], ge};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.finish) begin
      case (op_q)
        OP_RES: res_q <= num_q;
        OP_RATIO: begin
          ratio_q <= (num_q > NUM_W'({RATIO_W{1'b1}})) ? '1 : num_q[RATIO_W-1:0];
        end
        OP_DUTY, OP_POT: begin
          duty_q <= (num_q > NUM_W'(DUTY_FULL)) ? DUTY_FULL : num_q[DUTY_W-1:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.res_ot) begin
      res_q <= NUM_W'(ot_ohm_q);
    end
    if (cmd_i.mark_ot) begin
      ot_flag_q <= 1'b1;
      upd_q     <= 1'b1;
      duty_q    <= DUTY_FULL;
      ratio_q   <= '0;
    end
    if (cmd_i.duty_zero) begin
      duty_q <= DUTY_OFF;
    end
    if (cmd_i.front_duty) begin
      duty_q <= front_duty_val;
    end
    if (cmd_i.write) begin
      duty_percent_o <= duty_q;
      fan_channel_o  <= ch_q;
      over_temp_o    <= ot_flag_q;
      fault_send_o   <= pend_q && (flags_new != '0);
      fault_flags_o  <= flags_new;
      enclosure_ratio_o <= (upd_q && !ch_q) ? ratio_q : encl_q;
      dcdc_ratio_o      <= (upd_q && ch_q) ? ratio_q : dcdc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      encl_q      <= RATIO_RST;
      dcdc_q      <= RATIO_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        flags_q     <= pend_q ? '0 : flags_new;
        out_valid_q <= 1'b1;
        if (upd_q && !ch_q) begin
          encl_q <= ratio_q;
        end
        if (upd_q && ch_q) begin
          dcdc_q <= ratio_q;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.front        = front_q;
    status_o.front_direct = (ref_q == '0) || (smp_q == '0) ||
                            ({1'b0, smp_q} > pot_lim) || (pot_q == '0);
    status_o.near         = diff[MV_W] || (diff[MV_W-1:0] < margin_q) ||
                            (diff[MV_W-1:0] == '0);
    status_o.div_last     = (cnt_q == '0);
    status_o.op_res       = (op_q == OP_RES);
    status_o.res_le_ot    = (res_q <= NUM_W'(ot_ohm_q));
    status_o.ref_zero     = (ref_q == '0);
    status_o.duty_zero    = (enable_q <= ot_ohm_q) || (res_q >= NUM_W'(enable_q));
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

endmodule

/* sv/thermistor_fan_speed_control.sv */
// One transaction is handled at a time: in_stall_o stays high until the result is written. An item
// needs no quotient, one, or two (thermistor resistance, then duty or ratio); each is formed by
// the shared 28-step restoring divider, one quotient bit per cycle.
// Reset (rst_ni, asynchronous, active low) loads the register defaults, clears the period
// flags, sets both stored ratios to one and empties the output register.
module thermistor_fan_speed_control import tfsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [MV_W-1:0]       ref_mv_i,
  input  logic [MV_W-1:0]       sample_mv_i,
  input  logic                  channel_i,
  input  logic                  period_end_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DUTY_W-1:0]     duty_percent_o,
  output logic                  fan_channel_o,
  output logic                  over_temp_o,
  output logic                  fault_send_o,
  output logic [FLAG_W-1:0]     fault_flags_o,
  output logic [RATIO_W-1:0]    enclosure_ratio_o,
  output logic [RATIO_W-1:0]    dcdc_ratio_o
);

  cmd_t    cmd;
  status_t status;

  tfsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tfsc_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .ref_mv_i          (ref_mv_i),
    .sample_mv_i       (sample_mv_i),
    .channel_i         (channel_i),
    .period_end_i      (period_end_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .duty_percent_o    (duty_percent_o),
    .fan_channel_o     (fan_channel_o),
    .over_temp_o       (over_temp_o),
    .fault_send_o      (fault_send_o),
    .fault_flags_o     (fault_flags_o),
    .enclosure_ratio_o (enclosure_ratio_o),
    .dcdc_ratio_o      (dcdc_ratio_o)
  );

endmodule
